// ===== hw/rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Request and response payloads, operation and status codes, and the
// circular index helpers used by the queue control.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Number of entries held by the queue
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // Operation codes
  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_e;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Request payload
  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  // Response payload
  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         fill_count;
  } rsp_t;

  // Advance a position by an offset below CAPACITY, wrapping once
  function automatic addr_t wrap_add(addr_t pos, cnt_t off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, pos} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Step a position back by one, wrapping at zero
  function automatic addr_t wrap_dec(addr_t pos);
    addr_t res;
    if (pos == '0) begin
      res = ADDR_W'(CAPACITY - 1);
    end else begin
      res = pos - ADDR_W'(1);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit: double-ended queue of signed 32-bit words
// Push or pop at either end of a circular buffer held in one RAM; every
// request yields one response with the popped word, a status and the fill.
// ----------------------------------------------------------------------------
//  channel   | signals           | transfer
//  ----------+-------------------+-------------------------------------------
//  request   | start, busy, req  | edge with start high and busy low
//  response  | done, rsp         | edge ending the single cycle done is high
//
//  One request is taken every cycle; busy stays low. The response appears
//  in the cycle after the request transfer, as the RAM read port that
//  returns the popped word is registered. Head and fill registers update
//  at the request edge, so a pop right after a push to the same entry
//  reads the new word. Reset clears head, fill and done; the RAM needs
//  no clearing. The receiver cannot stall, so the response is never held.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  deq_pkg::req_t req,
  output logic          done,
  output deq_pkg::rsp_t rsp
);

  deq_pkg::addr_t head;
  deq_pkg::addr_t head_next;
  deq_pkg::cnt_t  count;
  deq_pkg::cnt_t  count_next;

  logic           accept;
  logic           is_push;
  logic           full;
  logic           empty;
  logic           mem_we;
  logic           mem_re;
  deq_pkg::addr_t waddr;
  deq_pkg::addr_t raddr;
  logic [deq_pkg::DATA_W-1:0] rdata;
  deq_pkg::status_e status_now;

  // Response stage registers
  logic             rsp_from_mem;
  deq_pkg::status_e rsp_status;
  deq_pkg::cnt_t    rsp_fill;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_push = (req.req_type == deq_pkg::REQ_PUSH_FRONT) ||
                   (req.req_type == deq_pkg::REQ_PUSH_REAR);
  assign full    = (count == deq_pkg::CNT_W'(deq_pkg::CAPACITY));
  assign empty   = (count == '0);

  // Decode request: addresses, RAM strobes and next pointer state
  always_comb begin
    head_next  = head;
    count_next = count;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    waddr      = head;
    raddr      = head;
    status_now = deq_pkg::ST_OK;
    if (is_push && full) begin
      status_now = deq_pkg::ST_OVERFLOW;
    end else if (!is_push && empty) begin
      status_now = deq_pkg::ST_UNDERFLOW;
    end
    case (req.req_type)
      deq_pkg::REQ_PUSH_FRONT: begin
        waddr = deq_pkg::wrap_dec(head);
      end
      deq_pkg::REQ_PUSH_REAR: begin
        waddr = deq_pkg::wrap_add(head, count);
      end
      deq_pkg::REQ_POP_FRONT: begin
        raddr = head;
      end
      deq_pkg::REQ_POP_REAR: begin
        raddr = deq_pkg::wrap_add(head, count - deq_pkg::CNT_W'(1));
      end
      default: begin
        raddr = head;
      end
    endcase
    if (accept && status_now == deq_pkg::ST_OK) begin
      if (is_push) begin
        mem_we     = 1'b1;
        count_next = count + deq_pkg::CNT_W'(1);
        if (req.req_type == deq_pkg::REQ_PUSH_FRONT) begin
          head_next = waddr;
        end
      end else begin
        mem_re     = 1'b1;
        count_next = count - deq_pkg::CNT_W'(1);
        if (req.req_type == deq_pkg::REQ_POP_FRONT) begin
          head_next = deq_pkg::wrap_add(head, deq_pkg::CNT_W'(1));
        end
      end
    end
  end

  // Pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Response strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  // Response payload, aligned with the RAM read
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_from_mem <= mem_re;
      rsp_status   <= status_now;
      rsp_fill     <= count_next;
    end
  end

  deq_ram #(
    .DEPTH (deq_pkg::CAPACITY),
    .WIDTH (deq_pkg::DATA_W),
    .ADDR_W(deq_pkg::ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(waddr),
    .wdata(req.push_value),
    .re   (mem_re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Select popped word, fail marker or zero
  always_comb begin
    rsp.status     = rsp_status;
    rsp.fill_count = rsp_fill;
    if (rsp_from_mem) begin
      rsp.pop_value = rdata;
    end else if (rsp_status == deq_pkg::ST_UNDERFLOW) begin
      rsp.pop_value = '1;
    end else begin
      rsp.pop_value = '0;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= deq_pkg::CNT_W'(deq_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_one_rsp: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("request transfer without response");

  a_no_extra_rsp: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("response without request transfer");

  a_fail_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && status_now != deq_pkg::ST_OK) |=> (count == $past(count) &&
      head == $past(head)))
    else $error("failed request changed queue state");

  a_underflow_val: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == deq_pkg::ST_UNDERFLOW) |-> (rsp.pop_value == '1 &&
      rsp.fill_count == '0))
    else $error("underflow response malformed");

endmodule

// ===== hw/rtl/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== test/double_ended_queue_unit_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit_tb: self-checking bench for the double-ended queue
// Drives push and pop requests at both ends and predicts every response from
// a software copy of the circular buffer. Covers underflow on an empty queue,
// index wrap at the front and a queue drained back to empty. Random traffic
// mixes fill-heavy, drain-heavy and balanced episodes under three sender idle
// profiles; fill-heavy episodes can reach overflow when full.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT   = 64;

  logic          clk   = 1'b0;
  logic          rst   = 1'b1;
  logic          start = 1'b0;
  deq_pkg::req_t req   = '0;
  logic          busy;
  logic          done;
  deq_pkg::rsp_t rsp;

  // Software copy of the queue
  logic signed [deq_pkg::DATA_W-1:0] shadow_store [deq_pkg::CAPACITY];
  int                                shadow_head;
  int                                shadow_count;

  deq_pkg::rsp_t pending_responses[$];
  int            error_count = 0;
  int            sender_idle_pct = 0;

  double_ended_queue_unit dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always #10 clk = ~clk;

  // Apply one request to the software queue and return its response
  function automatic deq_pkg::rsp_t queue_response(deq_pkg::req_t r);
    deq_pkg::rsp_t resp;
    int            pos;
    resp.pop_value = '0;
    resp.status    = deq_pkg::ST_OK;
    case (deq_pkg::req_e'(r.req_type))
      deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_REAR: begin
        if (shadow_count >= deq_pkg::CAPACITY) begin
          resp.status = deq_pkg::ST_OVERFLOW;
        end else if (deq_pkg::req_e'(r.req_type) == deq_pkg::REQ_PUSH_FRONT) begin
          shadow_head = (shadow_head + deq_pkg::CAPACITY - 1) % deq_pkg::CAPACITY;
          shadow_store[shadow_head] = r.push_value;
          shadow_count++;
        end else begin
          pos = (shadow_head + shadow_count) % deq_pkg::CAPACITY;
          shadow_store[pos] = r.push_value;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          resp.status    = deq_pkg::ST_UNDERFLOW;
          resp.pop_value = -1;
        end else if (deq_pkg::req_e'(r.req_type) == deq_pkg::REQ_POP_FRONT) begin
          resp.pop_value = shadow_store[shadow_head];
          shadow_head = (shadow_head + 1) % deq_pkg::CAPACITY;
          shadow_count--;
        end else begin
          pos = (shadow_head + shadow_count - 1) % deq_pkg::CAPACITY;
          resp.pop_value = shadow_store[pos];
          shadow_count--;
        end
      end
    endcase
    resp.fill_count = deq_pkg::cnt_t'(shadow_count);
    return resp;
  endfunction

  // Send one request, idling first at the current sender rate
  task automatic issue_request(input deq_pkg::req_e op,
                               input logic signed [deq_pkg::DATA_W-1:0] word);
    deq_pkg::req_t item;
    deq_pkg::req_t noise;
    item.req_type   = op;
    item.push_value = word;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      noise.req_type   = 2'($urandom);
      noise.push_value = $urandom;
      start <= 1'b0;
      req   <= noise;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_responses.push_back(queue_response(item));
  endtask

  // Check each response against the oldest prediction
  always @(posedge clk) begin
    deq_pkg::rsp_t exp_rsp;
    if (!rst && done) begin
      if (pending_responses.size() == 0) begin
        $error("unexpected response: pop_value %0d status %0d fill_count %0d",
               rsp.pop_value, rsp.status, rsp.fill_count);
        error_count++;
      end else begin
        exp_rsp = pending_responses.pop_front();
        if (rsp.pop_value !== exp_rsp.pop_value) begin
          $error("pop_value: expected %0d, got %0d", exp_rsp.pop_value, rsp.pop_value);
          error_count++;
        end
        if (rsp.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
          error_count++;
        end
        if (rsp.fill_count !== exp_rsp.fill_count) begin
          $error("fill_count: expected %0d, got %0d", exp_rsp.fill_count, rsp.fill_count);
          error_count++;
        end
      end
    end
  end

  // Pop both ends of the empty queue right after reset
  task automatic test_empty_pops();
    issue_request(deq_pkg::REQ_POP_FRONT, 32'sd5);
    issue_request(deq_pkg::REQ_POP_REAR, -32'sd5);
  endtask

  // Push at the front from head zero so the index wraps; use extreme words
  task automatic test_front_wrap();
    issue_request(deq_pkg::REQ_PUSH_FRONT, 32'sh8000_0000);
    issue_request(deq_pkg::REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
    issue_request(deq_pkg::REQ_PUSH_REAR, 32'sd0);
    issue_request(deq_pkg::REQ_PUSH_REAR, -32'sd1);
    issue_request(deq_pkg::REQ_POP_REAR, 32'sd0);
    issue_request(deq_pkg::REQ_POP_FRONT, 32'sh5555_5555);
    issue_request(deq_pkg::REQ_POP_FRONT, 32'shAAAA_AAAA);
    issue_request(deq_pkg::REQ_POP_REAR, 32'sd0);
    issue_request(deq_pkg::REQ_POP_REAR, 32'sd0);
  endtask

  // Empty the queue mid-buffer; head holds its position
  task automatic test_drain_to_empty();
    issue_request(deq_pkg::REQ_PUSH_REAR, 32'sd1);
    issue_request(deq_pkg::REQ_POP_FRONT, 32'sd0);
    issue_request(deq_pkg::REQ_PUSH_FRONT, 32'sd2);
    issue_request(deq_pkg::REQ_POP_REAR, 32'sd0);
    issue_request(deq_pkg::REQ_POP_FRONT, 32'sd0);
    issue_request(deq_pkg::REQ_PUSH_REAR, 32'sd3);
    issue_request(deq_pkg::REQ_POP_REAR, 32'sd0);
  endtask

  // Random traffic in fill-heavy, drain-heavy and balanced episodes
  task automatic test_random_traffic(input int n_items, input int idle_pct);
    int                                sent;
    int                                run_len;
    int                                push_pct;
    int                                mode;
    logic signed [deq_pkg::DATA_W-1:0] word;
    logic                              is_push;
    logic                              at_front;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      mode    = $urandom_range(2);
      run_len = $urandom_range(120, 8);
      if (run_len > n_items - sent) begin
        run_len = n_items - sent;
      end
      push_pct = (mode == 0) ? 88 : (mode == 1) ? 12 : 50;
      repeat (run_len) begin
        is_push  = ($urandom_range(99) < push_pct);
        at_front = 1'($urandom_range(1));
        case ($urandom_range(15))
          0:       word = 32'sh8000_0000;
          1:       word = 32'sh7FFF_FFFF;
          2:       word = -32'sd1;
          3:       word = 32'sd0;
          default: word = $urandom;
        endcase
        if (is_push) begin
          issue_request(at_front ? deq_pkg::REQ_PUSH_FRONT : deq_pkg::REQ_PUSH_REAR, word);
        end else begin
          issue_request(at_front ? deq_pkg::REQ_POP_FRONT : deq_pkg::REQ_POP_REAR, word);
        end
        sent++;
      end
    end
  endtask

  // Sequence the tests and report
  initial begin
    int waited;
    shadow_head  = 0;
    shadow_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 16;
    test_empty_pops();
    test_front_wrap();
    test_drain_to_empty();
    test_random_traffic(300, 16);
    test_random_traffic(300, 63);
    test_random_traffic(300, 0);
    start <= 1'b0;

    // Drain outstanding responses
    waited = 0;
    while (pending_responses.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_responses.size() != 0) begin
      $error("%0d responses never arrived", pending_responses.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop on a hung run
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
